// ===== rtl/gpv_pkg.sv =====
// shared types, constants and helpers for the grouped plurality vote block
package gpv_pkg;

	localparam int SYM_COUNT   = 32;
	localparam int SYM_W       = 5;
	localparam int IN_W        = 6;
	localparam int CNT_W       = 9;
	localparam int CFG_W       = 9;
	localparam int IDX_W       = 8;
	localparam int MAX_GROUP   = 256;
	localparam int QUEUE_DEPTH = 2;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [1:0] REG_GROUP_LENGTH     = 2'd0;
	localparam logic [1:0] REG_GROUPS_PER_FRAME = 2'd1;
	localparam logic [1:0] REG_MIN_VOTES        = 2'd2;

	localparam logic [IN_W-1:0] SYM_NONE = '1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FEW     = 2'd1,
		ST_INVALID = 2'd2,
		ST_BADCFG  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		K_SYM  = 2'd0,
		K_NONE = 2'd1,
		K_BAD  = 2'd2
	} kind_t;

	typedef struct packed {
		logic             start;
		kind_t            kind;
		logic [SYM_W-1:0] idx;
	} qword_t;

	typedef struct packed {
		logic [CFG_W-1:0] group_length;
		logic [CFG_W-1:0] groups_per_frame;
		logic [CFG_W-1:0] min_votes;
	} cfg_t;

	function automatic logic [CFG_W-1:0] eff(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] r;
		if (v == '0) begin
			r = CFG_W'(1);
		end else if (v > CFG_W'(MAX_GROUP)) begin
			r = CFG_W'(MAX_GROUP);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/gpv_ifs.sv =====
// symbol and result channel interfaces
interface gpv_sym_if;
	logic                              valid;
	logic                              ready;
	logic signed [gpv_pkg::IN_W-1:0]   symbol;
	logic                              frame_start;

	modport source(output valid, symbol, frame_start, input ready);
	modport sink(input valid, symbol, frame_start, output ready);
endinterface

interface gpv_res_if;
	logic                            valid;
	logic                            ready;
	logic [gpv_pkg::SYM_W-1:0]       winner;
	logic [gpv_pkg::CNT_W-1:0]       votes;
	gpv_pkg::status_t                status;
	logic [gpv_pkg::IDX_W-1:0]       group_index;
	logic                            frame_done;

	modport source(output valid, winner, votes, status, group_index, frame_done, input ready);
	modport sink(input valid, winner, votes, status, group_index, frame_done, output ready);
endinterface

// ===== rtl/gpv_cfg.sv =====
// apb register file for the vote settings
module gpv_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gpv_pkg::ADDR_W-1:0]  paddr,
	input  logic [gpv_pkg::DATA_W-1:0]  pwdata,
	output logic [gpv_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output gpv_pkg::cfg_t               cfg
);

	logic [gpv_pkg::CFG_W-1:0] group_length_q;
	logic [gpv_pkg::CFG_W-1:0] groups_per_frame_q;
	logic [gpv_pkg::CFG_W-1:0] min_votes_q;
	logic [1:0]                sel;
	logic                      wr;

	assign sel    = paddr[gpv_pkg::ADDR_W-1:2];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_length_q     <= gpv_pkg::CFG_W'(5);
			groups_per_frame_q <= gpv_pkg::CFG_W'(1);
			min_votes_q        <= '0;
		end else if (wr) begin
			unique case (sel)
				gpv_pkg::REG_GROUP_LENGTH:     group_length_q     <= pwdata[gpv_pkg::CFG_W-1:0];
				gpv_pkg::REG_GROUPS_PER_FRAME: groups_per_frame_q <= pwdata[gpv_pkg::CFG_W-1:0];
				gpv_pkg::REG_MIN_VOTES:        min_votes_q        <= pwdata[gpv_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (sel)
			gpv_pkg::REG_GROUP_LENGTH:     prdata = gpv_pkg::DATA_W'(group_length_q);
			gpv_pkg::REG_GROUPS_PER_FRAME: prdata = gpv_pkg::DATA_W'(groups_per_frame_q);
			gpv_pkg::REG_MIN_VOTES:        prdata = gpv_pkg::DATA_W'(min_votes_q);
			default:                       prdata = '0;
		endcase
	end

	assign cfg.group_length     = group_length_q;
	assign cfg.groups_per_frame = groups_per_frame_q;
	assign cfg.min_votes        = min_votes_q;

endmodule

// ===== rtl/gpv_front.sv =====
// input side: symbol classification and a short word queue
module gpv_front (
	input  logic              clk,
	input  logic              arst_n,
	gpv_sym_if.sink           symbols,
	output logic              q_valid,
	output gpv_pkg::qword_t   q_word,
	input  logic              q_pop
);

	localparam int PTR_W = $clog2(gpv_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(gpv_pkg::QUEUE_DEPTH + 1);

	gpv_pkg::qword_t  mem_q [gpv_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	gpv_pkg::qword_t  in_word;
	logic             push;
	logic             pop;

	always_comb begin
		in_word.start = symbols.frame_start;
		in_word.idx   = symbols.symbol[gpv_pkg::SYM_W-1:0];
		if (!symbols.symbol[gpv_pkg::IN_W-1]) begin
			in_word.kind = gpv_pkg::K_SYM;
		end else if (symbols.symbol == gpv_pkg::SYM_NONE) begin
			in_word.kind = gpv_pkg::K_NONE;
		end else begin
			in_word.kind = gpv_pkg::K_BAD;
		end
	end

	assign symbols.ready = (count_q != CNT_W'(gpv_pkg::QUEUE_DEPTH));
	assign push          = symbols.valid & symbols.ready;
	assign q_valid       = (count_q != '0);
	assign pop           = q_pop & q_valid;
	assign q_word        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(gpv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(gpv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/gpv_back.sv =====
// vote side: histogram, running leader, group and frame tracking, result register
module gpv_back (
	input  logic              clk,
	input  logic              arst_n,
	input  gpv_pkg::cfg_t     cfg,
	input  logic              q_valid,
	input  gpv_pkg::qword_t   q_word,
	output logic              q_pop,
	gpv_res_if.source         results
);

	localparam int C = gpv_pkg::CNT_W;

	logic [C-1:0]                  tally_q [gpv_pkg::SYM_COUNT];
	logic [gpv_pkg::SYM_COUNT-1:0] seen_q;
	logic [C-1:0]                  best_cnt_q;
	logic [gpv_pkg::SYM_W-1:0]     best_sym_q;
	logic [C-1:0]                  pos_q;
	logic [C-1:0]                  group_q;
	logic                          bad_q;
	logic                          failed_q;

	logic                          out_valid_q;
	logic [gpv_pkg::SYM_W-1:0]     winner_q;
	logic [C-1:0]                  votes_q;
	gpv_pkg::status_t              status_q;
	logic [gpv_pkg::IDX_W-1:0]     gidx_q;
	logic                          done_q;

	logic [C-1:0]                  gl, gpf;
	logic [gpv_pkg::SYM_COUNT-1:0] cur_seen;
	logic [C-1:0]                  cur_best, cur_pos, cur_group, entry, cnt_new;
	logic [gpv_pkg::SYM_W-1:0]     cur_sym;
	logic                          cur_bad, ignore, is_sym, new_best, bad_next, group_end;
	logic [C-1:0]                  best_next, pos_next, votes_r;
	logic [gpv_pkg::SYM_W-1:0]     sym_next, winner_r;
	gpv_pkg::status_t              status_r;
	logic                          done_r, emit;

	assign gl  = gpv_pkg::eff(cfg.group_length);
	assign gpf = gpv_pkg::eff(cfg.groups_per_frame);

	assign q_pop = q_valid & (~out_valid_q | results.ready);

	always_comb begin
		cur_seen  = q_word.start ? '0 : seen_q;
		cur_best  = q_word.start ? '0 : best_cnt_q;
		cur_sym   = q_word.start ? '0 : best_sym_q;
		cur_pos   = q_word.start ? '0 : pos_q;
		cur_group = q_word.start ? '0 : group_q;
		cur_bad   = q_word.start ? 1'b0 : bad_q;
		ignore    = (q_word.start ? 1'b0 : failed_q) | (cur_group >= gpf);

		is_sym    = (q_word.kind == gpv_pkg::K_SYM);
		entry     = cur_seen[q_word.idx] ? tally_q[q_word.idx] : '0;
		cnt_new   = entry + 1'b1;
		new_best  = is_sym & (cnt_new > cur_best);
		best_next = new_best ? cnt_new : cur_best;
		sym_next  = new_best ? q_word.idx : cur_sym;
		bad_next  = cur_bad | (q_word.kind == gpv_pkg::K_BAD);
		pos_next  = cur_pos + 1'b1;
		group_end = ~ignore & (pos_next >= gl);

		winner_r = sym_next;
		votes_r  = best_next;
		if (cfg.min_votes > gl) begin
			status_r = gpv_pkg::ST_BADCFG;
			winner_r = '0;
			votes_r  = '0;
		end else if (bad_next) begin
			status_r = gpv_pkg::ST_INVALID;
			winner_r = '0;
			votes_r  = '0;
		end else if ((cfg.min_votes != '0) && (best_next < cfg.min_votes)) begin
			status_r = gpv_pkg::ST_FEW;
		end else begin
			status_r = gpv_pkg::ST_OK;
		end
		done_r = (status_r != gpv_pkg::ST_OK) | (cur_group >= gpf - 1'b1);
		emit   = q_pop & group_end;
	end

	// histogram entries
	always_ff @(posedge clk) begin
		if (q_pop && !ignore && is_sym) begin
			tally_q[q_word.idx] <= cnt_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q     <= '0;
			best_cnt_q <= '0;
			best_sym_q <= '0;
			pos_q      <= '0;
			group_q    <= '0;
			bad_q      <= 1'b0;
			failed_q   <= 1'b0;
		end else if (q_pop) begin
			if (ignore) begin
				seen_q     <= cur_seen;
				best_cnt_q <= cur_best;
				best_sym_q <= cur_sym;
				pos_q      <= cur_pos;
				group_q    <= cur_group;
				bad_q      <= cur_bad;
				failed_q   <= q_word.start ? 1'b0 : failed_q;
			end else if (group_end) begin
				seen_q     <= '0;
				best_cnt_q <= '0;
				best_sym_q <= '0;
				pos_q      <= '0;
				group_q    <= cur_group + 1'b1;
				bad_q      <= 1'b0;
				failed_q   <= (status_r != gpv_pkg::ST_OK);
			end else begin
				seen_q     <= is_sym ? (cur_seen | (gpv_pkg::SYM_COUNT'(1) << q_word.idx))
				                     : cur_seen;
				best_cnt_q <= best_next;
				best_sym_q <= sym_next;
				pos_q      <= pos_next;
				group_q    <= cur_group;
				bad_q      <= bad_next;
				failed_q   <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			winner_q <= winner_r;
			votes_q  <= votes_r;
			status_q <= status_r;
			gidx_q   <= cur_group[gpv_pkg::IDX_W-1:0];
			done_q   <= done_r;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.winner      = winner_q;
	assign results.votes       = votes_q;
	assign results.status      = status_q;
	assign results.group_index = gidx_q;
	assign results.frame_done  = done_q;

endmodule

// ===== rtl/grouped_plurality_vote_core.sv =====
// top level of the grouped plurality vote block
// usage:
//   symbols carries one detected symbol per word (0..31, -1 for none) and a
//   frame_start flag; results carries winner, votes, status, group_index and
//   frame_done, one word at the end of each counted group
//   settings (group_length, groups_per_frame, min_votes) are written over the
//   apb port at byte addresses 0, 4 and 8 while the block is idle
//   a word that ends a group has its result valid on results after it has
//   passed the two-entry input queue: acceptance writes it into the queue,
//   and its pop updates the histogram and loads the result register
//   one word per cycle is sustained while results is not stalled; the histogram
//   read, increment and leader compare are combinational for each word
//   when results stalls, the result register holds and the queue fills; ready
//   on symbols drops once both queue entries are taken
//   reset clears the queue, the result valid flag and the group and frame
//   state; settings return to group_length 5, groups_per_frame 1, min_votes 0,
//   and a frame is open at group 0
module grouped_plurality_vote_core (
	input  logic                        clk,
	input  logic                        arst_n,
	gpv_sym_if.sink                     symbols,
	gpv_res_if.source                   results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gpv_pkg::ADDR_W-1:0]  paddr,
	input  logic [gpv_pkg::DATA_W-1:0]  pwdata,
	output logic [gpv_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	gpv_pkg::cfg_t   cfg;
	logic            q_valid;
	logic            q_pop;
	gpv_pkg::qword_t q_word;

	gpv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gpv_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.symbols (symbols),
		.q_valid (q_valid),
		.q_word  (q_word),
		.q_pop   (q_pop)
	);

	gpv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (q_valid),
		.q_word  (q_word),
		.q_pop   (q_pop),
		.results (results)
	);

endmodule
